/* rtl/core/alarm_clock_panel_controller_unit_macros.svh */
// Assertion macros shared by the alarm clock panel controller RTL.
`ifndef ALARM_CLOCK_PANEL_CONTROLLER_UNIT_MACROS_SVH
`define ALARM_CLOCK_PANEL_CONTROLLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACPC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/acpc_pkg.sv */
// Types, constants and wrap helpers of the alarm clock panel controller.
`default_nettype none

package acpc_pkg;

	localparam int NUM_SLOTS_DEF = 5;

	localparam int BTN_MODE  = 0;
	localparam int BTN_INC   = 1;
	localparam int BTN_DEC   = 2;
	localparam int BTN_SET   = 3;
	localparam int BTN_ALARM = 4;

	localparam logic [7:0] MIN_MAX   = 8'd59;
	localparam logic [7:0] HOUR_MAX  = 8'd23;
	localparam logic [7:0] DAY_MAX   = 8'd31;
	localparam logic [7:0] WDAY_MAX  = 8'd6;
	localparam logic [7:0] MONTH_MAX = 8'd12;
	localparam logic [7:0] YEAR_MAX  = 8'd99;
	localparam logic [7:0] SEC_LAST_REARM = 8'd3;

	typedef enum logic [2:0] {
		FLD_MIN   = 3'd0,
		FLD_HOUR  = 3'd1,
		FLD_DAY   = 3'd2,
		FLD_MONTH = 3'd3,
		FLD_YEAR  = 3'd4
	} field_sel_t;

	typedef enum logic [1:0] {
		UI_NORMAL      = 2'd0,
		UI_TIME_EDIT   = 2'd1,
		UI_SLOT_CHOOSE = 2'd2,
		UI_ALARM_VALUE = 2'd3
	} ui_mode_t;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] day;
		logic [2:0] wday;
		logic [3:0] month;
		logic [6:0] year;
		logic [4:0] buttons;
	} item_t;

	typedef struct packed {
		logic       buzzer_pulse;
		logic       time_write;
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hour;
		logic [4:0] day;
		logic [2:0] wday;
		logic [3:0] month;
		logic [6:0] year;
		field_sel_t edit_field;
		ui_mode_t   ui_mode;
		logic       ringing;
	} result_t;

	// Step up by one, returning to lo once the top value is passed.
	function automatic logic [7:0] wrap_inc(logic [7:0] v, logic [7:0] top, logic [7:0] lo);
		return (v >= top) ? lo : v + 8'd1;
	endfunction

	// Step down by one, returning to top once the bottom value is passed.
	function automatic logic [7:0] wrap_dec(logic [7:0] v, logic [7:0] lo, logic [7:0] top);
		return (v <= lo) ? top : v - 8'd1;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/alarm_clock_panel_controller_unit.sv */
// Alarm clock front-panel controller: one polling item in, one result item out.
// Input and result are registered; all slot compares and edits are combinational.
// Throughput is one item per cycle while the output does not stall.
// An output stall holds the result register and then the input register.
// Reset clears the modes, pointers, ringing state and slots, and arms every slot.
`default_nettype none
`include "alarm_clock_panel_controller_unit_macros.svh"

module alarm_clock_panel_controller_unit #(
	parameter int NUM_SLOTS = acpc_pkg::NUM_SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [5:0] now_sec,
	input  wire logic [5:0] now_min,
	input  wire logic [4:0] now_hour,
	input  wire logic [4:0] now_day,
	input  wire logic [2:0] now_wday,
	input  wire logic [3:0] now_month,
	input  wire logic [6:0] now_year,
	input  wire logic [4:0] buttons,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            buzzer_pulse,
	output logic            time_write,
	output logic [5:0]      new_sec,
	output logic [5:0]      new_min,
	output logic [4:0]      new_hour,
	output logic [4:0]      new_day,
	output logic [2:0]      new_wday,
	output logic [3:0]      new_month,
	output logic [6:0]      new_year,
	output logic [2:0]      edit_field,
	output logic [1:0]      ui_mode,
	output logic            ringing
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

	acpc_pkg::item_t   item_s1;
	logic              v_s1;
	acpc_pkg::result_t res_q;
	logic              out_v_q;
	logic              out_free;
	logic              adv;

	logic                   time_edit_q, time_edit_n;
	acpc_pkg::field_sel_t   field_q, field_n;
	logic                   alarm_edit_q, alarm_edit_n;
	logic                   chosen_q, chosen_n;
	logic                   afh_q, afh_n;
	logic [SLOT_W-1:0]      ptr_q, ptr_n;
	logic [SLOT_W-1:0]      ring_slot_q, ring_slot_n;
	logic                   ring_flag_q, ring_flag_n;
	logic [5:0]             slot_min_q [NUM_SLOTS];
	logic [5:0]             slot_min_n [NUM_SLOTS];
	logic [4:0]             slot_hour_q [NUM_SLOTS];
	logic [4:0]             slot_hour_n [NUM_SLOTS];
	logic [NUM_SLOTS-1:0]   slot_set_q, slot_set_n;
	logic [NUM_SLOTS-1:0]   slot_armed_q, slot_armed_n;

	acpc_pkg::result_t res_n;
	logic              b_mode, b_inc, b_dec, b_set, b_alarm;
	logic              midnight;
	logic              write;
	logic [5:0]        sec, mn, amin;
	logic [4:0]        hr, dy, ahour;
	logic [2:0]        wd;
	logic [3:0]        mo;
	logic [6:0]        yr;

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = v_s1 && !out_free;
	assign adv      = v_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (!in_stall) v_s1 <= in_valid;
			if (out_free) out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= '{sec: now_sec, min: now_min, hour: now_hour, day: now_day,
				wday: now_wday, month: now_month, year: now_year, buttons: buttons};
		end
		if (adv) res_q <= res_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_edit_q  <= 1'b0;
			field_q      <= acpc_pkg::FLD_MIN;
			alarm_edit_q <= 1'b0;
			chosen_q     <= 1'b0;
			afh_q        <= 1'b0;
			ptr_q        <= '0;
			ring_slot_q  <= '0;
			ring_flag_q  <= 1'b0;
			slot_set_q   <= '0;
			slot_armed_q <= '1;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_min_q[i]  <= '0;
				slot_hour_q[i] <= '0;
			end
		end else if (adv) begin
			time_edit_q  <= time_edit_n;
			field_q      <= field_n;
			alarm_edit_q <= alarm_edit_n;
			chosen_q     <= chosen_n;
			afh_q        <= afh_n;
			ptr_q        <= ptr_n;
			ring_slot_q  <= ring_slot_n;
			ring_flag_q  <= ring_flag_n;
			slot_set_q   <= slot_set_n;
			slot_armed_q <= slot_armed_n;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				slot_min_q[i]  <= slot_min_n[i];
				slot_hour_q[i] <= slot_hour_n[i];
			end
		end
	end

	always_comb begin
		b_mode  = item_s1.buttons[acpc_pkg::BTN_MODE];
		b_inc   = item_s1.buttons[acpc_pkg::BTN_INC];
		b_dec   = item_s1.buttons[acpc_pkg::BTN_DEC];
		b_set   = item_s1.buttons[acpc_pkg::BTN_SET];
		b_alarm = item_s1.buttons[acpc_pkg::BTN_ALARM];

		sec = item_s1.sec;
		mn  = item_s1.min;
		hr  = item_s1.hour;
		dy  = item_s1.day;
		wd  = item_s1.wday;
		mo  = item_s1.month;
		yr  = item_s1.year;

		write  = 1'b0;
		res_n  = '0;
		amin   = slot_min_q[ptr_q];
		ahour  = slot_hour_q[ptr_q];

		time_edit_n = time_edit_q;
		field_n     = field_q;
		chosen_n    = chosen_q;
		afh_n       = afh_q;
		ptr_n       = ptr_q;
		ring_slot_n = ring_slot_q;
		ring_flag_n = ring_flag_q;
		slot_set_n  = slot_set_q;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_min_n[i]  = slot_min_q[i];
			slot_hour_n[i] = slot_hour_q[i];
		end

		// Every slot is re-armed during the first seconds after midnight.
		midnight = (8'(item_s1.sec) <= acpc_pkg::SEC_LAST_REARM) && (item_s1.min == '0)
			&& (item_s1.hour == '0);
		slot_armed_n = midnight ? '1 : slot_armed_q;

		alarm_edit_n = alarm_edit_q || (b_alarm && !ring_flag_q);

		if (alarm_edit_n) begin
			if (!chosen_q) begin
				if (b_inc) ptr_n = (ptr_q >= SLOT_LAST) ? '0 : ptr_q + 1'b1;
				if (b_set) chosen_n = 1'b1;
			end else begin
				afh_n = afh_q ^ b_mode;
				if (b_inc) begin
					if (afh_n) ahour = 5'(acpc_pkg::wrap_inc(8'(ahour), acpc_pkg::HOUR_MAX, 8'd0));
					else amin = 6'(acpc_pkg::wrap_inc(8'(amin), acpc_pkg::MIN_MAX, 8'd0));
				end
				if (b_dec) begin
					if (afh_n) ahour = 5'(acpc_pkg::wrap_dec(8'(ahour), 8'd0, acpc_pkg::HOUR_MAX));
					else amin = 6'(acpc_pkg::wrap_dec(8'(amin), 8'd0, acpc_pkg::MIN_MAX));
				end
				slot_min_n[ptr_q]  = amin;
				slot_hour_n[ptr_q] = ahour;
				if (b_set) begin
					alarm_edit_n         = 1'b0;
					chosen_n             = 1'b0;
					slot_set_n[ptr_q]    = 1'b1;
					slot_armed_n[ptr_q]  = 1'b1;
				end
			end
		end else begin
			// The highest matching slot wins.
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (item_s1.min == slot_min_q[i] && item_s1.hour == slot_hour_q[i]
						&& slot_set_q[i] && slot_armed_n[i]) begin
					ring_slot_n        = SLOT_W'(i);
					ring_flag_n        = 1'b1;
					res_n.buzzer_pulse = 1'b1;
				end
			end
			if (b_alarm && ring_flag_n) begin
				slot_armed_n[ring_slot_n] = 1'b0;
				ring_flag_n               = 1'b0;
			end
			time_edit_n = time_edit_q || b_mode;
			if (time_edit_n && b_mode) begin
				field_n = (field_q >= acpc_pkg::FLD_YEAR) ? acpc_pkg::FLD_MIN
					: acpc_pkg::field_sel_t'(field_q + 3'd1);
			end
			if (time_edit_n && b_inc) begin
				unique case (field_n)
					acpc_pkg::FLD_MIN:   mn = 6'(acpc_pkg::wrap_inc(8'(mn), acpc_pkg::MIN_MAX, 8'd0));
					acpc_pkg::FLD_HOUR:  hr = 5'(acpc_pkg::wrap_inc(8'(hr), acpc_pkg::HOUR_MAX, 8'd0));
					acpc_pkg::FLD_DAY: begin
						dy = 5'(acpc_pkg::wrap_inc(8'(dy), acpc_pkg::DAY_MAX, 8'd1));
						wd = 3'(acpc_pkg::wrap_inc(8'(wd), acpc_pkg::WDAY_MAX, 8'd0));
					end
					acpc_pkg::FLD_MONTH: mo = 4'(acpc_pkg::wrap_inc(8'(mo), acpc_pkg::MONTH_MAX, 8'd1));
					acpc_pkg::FLD_YEAR:  yr = 7'(acpc_pkg::wrap_inc(8'(yr), acpc_pkg::YEAR_MAX, 8'd0));
					default: ;
				endcase
				write = 1'b1;
			end
			if (time_edit_n && b_dec) begin
				unique case (field_n)
					acpc_pkg::FLD_MIN:   mn = 6'(acpc_pkg::wrap_dec(8'(mn), 8'd0, acpc_pkg::MIN_MAX));
					acpc_pkg::FLD_HOUR:  hr = 5'(acpc_pkg::wrap_dec(8'(hr), 8'd0, acpc_pkg::HOUR_MAX));
					acpc_pkg::FLD_DAY: begin
						dy = 5'(acpc_pkg::wrap_dec(8'(dy), 8'd1, acpc_pkg::DAY_MAX));
						wd = 3'(acpc_pkg::wrap_dec(8'(wd), 8'd0, acpc_pkg::WDAY_MAX));
					end
					acpc_pkg::FLD_MONTH: mo = 4'(acpc_pkg::wrap_dec(8'(mo), 8'd1, acpc_pkg::MONTH_MAX));
					acpc_pkg::FLD_YEAR:  yr = 7'(acpc_pkg::wrap_dec(8'(yr), 8'd0, acpc_pkg::YEAR_MAX));
					default: ;
				endcase
				write = 1'b1;
			end
			if (time_edit_n && b_set) begin
				sec         = '0;
				time_edit_n = 1'b0;
				write       = 1'b1;
			end
		end

		res_n.time_write = write;
		if (write) begin
			res_n.sec   = sec;
			res_n.min   = mn;
			res_n.hour  = hr;
			res_n.day   = dy;
			res_n.wday  = wd;
			res_n.month = mo;
			res_n.year  = yr;
		end
		res_n.edit_field = field_n;
		res_n.ringing    = ring_flag_n;
		priority if (alarm_edit_n && chosen_n) res_n.ui_mode = acpc_pkg::UI_ALARM_VALUE;
		else if (alarm_edit_n)                 res_n.ui_mode = acpc_pkg::UI_SLOT_CHOOSE;
		else if (time_edit_n)                  res_n.ui_mode = acpc_pkg::UI_TIME_EDIT;
		else                                   res_n.ui_mode = acpc_pkg::UI_NORMAL;
	end

	assign out_valid    = out_v_q;
	assign buzzer_pulse = res_q.buzzer_pulse;
	assign time_write   = res_q.time_write;
	assign new_sec      = res_q.sec;
	assign new_min      = res_q.min;
	assign new_hour     = res_q.hour;
	assign new_day      = res_q.day;
	assign new_wday     = res_q.wday;
	assign new_month    = res_q.month;
	assign new_year     = res_q.year;
	assign edit_field   = res_q.edit_field;
	assign ui_mode      = res_q.ui_mode;
	assign ringing      = res_q.ringing;

	`ACPC_ASSERT_IMP(a_stall_cause, in_stall, v_s1 && out_v_q && out_stall, "Input stalled without a blocked result.")
	`ACPC_ASSERT_IMP(a_ptr_range, 1'b1, ptr_q <= SLOT_LAST, "Slot pointer beyond the last slot.")
	`ACPC_ASSERT_IMP(a_field_range, 1'b1, field_q <= acpc_pkg::FLD_YEAR, "Field selector out of range.")
	`ACPC_ASSERT_IMP(a_alarm_quiet, out_valid && (res_q.ui_mode == acpc_pkg::UI_SLOT_CHOOSE || res_q.ui_mode == acpc_pkg::UI_ALARM_VALUE), !buzzer_pulse && !time_write, "Buzzer or time write during alarm edit.")
	`ACPC_ASSERT_IMP(a_no_write_zero, out_valid && !time_write, new_sec == '0 && new_min == '0 && new_hour == '0 && new_day == '0 && new_wday == '0 && new_month == '0 && new_year == '0, "Time fields not cleared without a write.")

endmodule

`default_nettype wire

/* tb/panel_result_checker.sv */
// Checker for the alarm clock panel controller: predicts every result item and compares it.
module panel_result_checker #(
	parameter int NUM_SLOTS = acpc_pkg::NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [5:0] now_sec,
	input  logic [5:0] now_min,
	input  logic [4:0] now_hour,
	input  logic [4:0] now_day,
	input  logic [2:0] now_wday,
	input  logic [3:0] now_month,
	input  logic [6:0] now_year,
	input  logic [4:0] buttons,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       buzzer_pulse,
	input  logic       time_write,
	input  logic [5:0] new_sec,
	input  logic [5:0] new_min,
	input  logic [4:0] new_hour,
	input  logic [4:0] new_day,
	input  logic [2:0] new_wday,
	input  logic [3:0] new_month,
	input  logic [6:0] new_year,
	input  logic [2:0] edit_field,
	input  logic [1:0] ui_mode,
	input  logic       ringing,
	output int         errors,
	output int         pending
);
	import acpc_pkg::*;

	logic time_edit;
	logic alarm_edit;
	logic slot_chosen;
	logic edit_hour;
	logic ring_flag;
	int field_idx;
	int slot_ptr;
	int ring_slot;
	int al_min [NUM_SLOTS];
	int al_hour [NUM_SLOTS];
	logic al_set [NUM_SLOTS];
	logic armed [NUM_SLOTS];
	result_t due_results [$];
	int mismatches;

	function automatic int roll_up(int v, int top, int lo);
		v = v + 1;
		return (v > top) ? lo : v;
	endfunction

	function automatic int roll_down(int v, int lo, int top);
		v = v - 1;
		return (v < lo) ? top : v;
	endfunction

	function automatic result_t poll_pass(item_t it);
		int sec;
		int mn;
		int hr;
		int dy;
		int wd;
		int mo;
		int yr;
		int p;
		logic b_mode;
		logic b_inc;
		logic b_dec;
		logic b_set;
		logic b_alarm;
		logic buzz;
		logic wr;
		result_t r;
		sec = it.sec;
		mn = it.min;
		hr = it.hour;
		dy = it.day;
		wd = it.wday;
		mo = it.month;
		yr = it.year;
		b_mode = it.buttons[BTN_MODE];
		b_inc = it.buttons[BTN_INC];
		b_dec = it.buttons[BTN_DEC];
		b_set = it.buttons[BTN_SET];
		b_alarm = it.buttons[BTN_ALARM];
		buzz = 1'b0;
		wr = 1'b0;

		// Every slot is armed again during the first seconds after midnight.
		if (sec <= SEC_LAST_REARM && mn == 0 && hr == 0)
			foreach (armed[i])
				armed[i] = 1'b1;

		if (b_alarm && !ring_flag)
			alarm_edit = 1'b1;

		if (alarm_edit) begin
			p = slot_ptr;
			if (!slot_chosen) begin
				if (b_inc) begin
					p = p + 1;
					if (p > NUM_SLOTS - 1)
						p = 0;
					slot_ptr = p;
				end
				if (b_set)
					slot_chosen = 1'b1;
			end else begin
				if (b_mode)
					edit_hour = !edit_hour;
				if (b_inc) begin
					if (edit_hour)
						al_hour[p] = roll_up(al_hour[p], HOUR_MAX, 0);
					else
						al_min[p] = roll_up(al_min[p], MIN_MAX, 0);
				end
				if (b_dec) begin
					if (edit_hour)
						al_hour[p] = roll_down(al_hour[p], 0, HOUR_MAX);
					else
						al_min[p] = roll_down(al_min[p], 0, MIN_MAX);
				end
				if (b_set) begin
					alarm_edit = 1'b0;
					slot_chosen = 1'b0;
					al_set[p] = 1'b1;
					armed[p] = 1'b1;
				end
			end
		end else begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				if (mn == al_min[i] && hr == al_hour[i] && al_set[i] && armed[i]) begin
					ring_slot = i;
					ring_flag = 1'b1;
					buzz = 1'b1;
				end
			end
			if (b_alarm && ring_flag) begin
				armed[ring_slot] = 1'b0;
				ring_flag = 1'b0;
			end
			if (b_mode && !time_edit)
				time_edit = 1'b1;
			if (time_edit && b_mode) begin
				field_idx = field_idx + 1;
				if (field_idx > FLD_YEAR)
					field_idx = FLD_MIN;
			end
			if (b_inc && time_edit) begin
				case (field_sel_t'(3'(field_idx)))
					FLD_MIN: mn = roll_up(mn, MIN_MAX, 0);
					FLD_HOUR: hr = roll_up(hr, HOUR_MAX, 0);
					FLD_DAY: begin
						dy = roll_up(dy, DAY_MAX, 1);
						wd = roll_up(wd, WDAY_MAX, 0);
					end
					FLD_MONTH: mo = roll_up(mo, MONTH_MAX, 1);
					FLD_YEAR: yr = roll_up(yr, YEAR_MAX, 0);
					default: ;
				endcase
				wr = 1'b1;
			end
			if (b_dec && time_edit) begin
				case (field_sel_t'(3'(field_idx)))
					FLD_MIN: mn = roll_down(mn, 0, MIN_MAX);
					FLD_HOUR: hr = roll_down(hr, 0, HOUR_MAX);
					FLD_DAY: begin
						dy = roll_down(dy, 1, DAY_MAX);
						wd = roll_down(wd, 0, WDAY_MAX);
					end
					FLD_MONTH: mo = roll_down(mo, 1, MONTH_MAX);
					FLD_YEAR: yr = roll_down(yr, 0, YEAR_MAX);
					default: ;
				endcase
				wr = 1'b1;
			end
			if (b_set && time_edit) begin
				sec = 0;
				time_edit = 1'b0;
				wr = 1'b1;
			end
		end

		r.buzzer_pulse = buzz;
		r.time_write = wr;
		r.sec = wr ? 6'(sec) : 6'd0;
		r.min = wr ? 6'(mn) : 6'd0;
		r.hour = wr ? 5'(hr) : 5'd0;
		r.day = wr ? 5'(dy) : 5'd0;
		r.wday = wr ? 3'(wd) : 3'd0;
		r.month = wr ? 4'(mo) : 4'd0;
		r.year = wr ? 7'(yr) : 7'd0;
		r.edit_field = field_sel_t'(3'(field_idx));
		if (alarm_edit)
			r.ui_mode = slot_chosen ? UI_ALARM_VALUE : UI_SLOT_CHOOSE;
		else
			r.ui_mode = time_edit ? UI_TIME_EDIT : UI_NORMAL;
		r.ringing = ring_flag;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			time_edit = 1'b0;
			alarm_edit = 1'b0;
			slot_chosen = 1'b0;
			edit_hour = 1'b0;
			ring_flag = 1'b0;
			field_idx = FLD_MIN;
			slot_ptr = 0;
			ring_slot = 0;
			foreach (al_min[i]) begin
				al_min[i] = 0;
				al_hour[i] = 0;
				al_set[i] = 1'b0;
				armed[i] = 1'b1;
			end
			due_results.delete();
			mismatches = 0;
		end else begin
			if (in_valid && !in_stall)
				due_results.push_back(poll_pass(item_t'{now_sec, now_min, now_hour, now_day,
					now_wday, now_month, now_year, buttons}));
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("result item arrived with no expectation waiting");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					compare_field("buzzer_pulse", want.buzzer_pulse, buzzer_pulse);
					compare_field("time_write", want.time_write, time_write);
					compare_field("new_sec", want.sec, new_sec);
					compare_field("new_min", want.min, new_min);
					compare_field("new_hour", want.hour, new_hour);
					compare_field("new_day", want.day, new_day);
					compare_field("new_wday", want.wday, new_wday);
					compare_field("new_month", want.month, new_month);
					compare_field("new_year", want.year, new_year);
					compare_field("edit_field", want.edit_field, edit_field);
					compare_field("ui_mode", want.ui_mode, ui_mode);
					compare_field("ringing", want.ringing, ringing);
				end
			end
		end
		errors <= mismatches;
		pending <= due_results.size();
	end

endmodule

/* tb/testbench.sv */
// Testbench top for the alarm clock panel controller: clock, reset, stimulus and verdict.
module testbench;
	import acpc_pkg::*;

	localparam logic [4:0] PRESS_MODE  = 5'b1 << BTN_MODE;
	localparam logic [4:0] PRESS_INC   = 5'b1 << BTN_INC;
	localparam logic [4:0] PRESS_DEC   = 5'b1 << BTN_DEC;
	localparam logic [4:0] PRESS_SET   = 5'b1 << BTN_SET;
	localparam logic [4:0] PRESS_ALARM = 5'b1 << BTN_ALARM;
	localparam int ITEM_TARGET = 1650;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [5:0] now_sec;
	logic [5:0] now_min;
	logic [4:0] now_hour;
	logic [4:0] now_day;
	logic [2:0] now_wday;
	logic [3:0] now_month;
	logic [6:0] now_year;
	logic [4:0] buttons;
	logic out_valid;
	logic out_stall;
	logic buzzer_pulse;
	logic time_write;
	logic [5:0] new_sec;
	logic [5:0] new_min;
	logic [4:0] new_hour;
	logic [4:0] new_day;
	logic [2:0] new_wday;
	logic [3:0] new_month;
	logic [6:0] new_year;
	logic [2:0] edit_field;
	logic [1:0] ui_mode;
	logic ringing;
	int errors;
	int pending;
	int sent;
	logic calm;

	alarm_clock_panel_controller_unit uut (.*);
	panel_result_checker result_check (.*);

	always #5 clk = ~clk;

	function automatic item_t reading(input int s, m, h, d, w, mo, y, input logic [4:0] btn);
		item_t it;
		it.sec = 6'(s);
		it.min = 6'(m);
		it.hour = 5'(h);
		it.day = 5'(d);
		it.wday = 3'(w);
		it.month = 4'(mo);
		it.year = 7'(y);
		it.buttons = btn;
		return it;
	endfunction

	// Minutes and hours are drawn mostly near the values that edited alarm slots take.
	function automatic item_t clock_reading(logic [4:0] btn);
		item_t it;
		it.sec = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 3))
			: 6'($urandom_range(0, 59));
		case ($urandom_range(0, 9))
			0, 1, 2: it.min = 0;
			3: it.min = 1;
			4: it.min = 59;
			5: it.min = 58;
			default: it.min = 6'($urandom_range(0, 59));
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2: it.hour = 0;
			3, 4: it.hour = 1;
			5, 6: it.hour = 23;
			default: it.hour = 5'($urandom_range(0, 23));
		endcase
		it.day = 5'($urandom_range(1, 31));
		it.wday = 3'($urandom_range(0, 6));
		it.month = 4'($urandom_range(1, 12));
		it.year = 7'($urandom_range(0, 99));
		it.buttons = btn;
		return it;
	endfunction

	function automatic logic [4:0] edit_keys();
		case ($urandom_range(0, 4))
			0: return PRESS_MODE;
			1: return PRESS_INC;
			2: return PRESS_DEC;
			3: return PRESS_MODE | PRESS_INC;
			default: return PRESS_INC | PRESS_DEC;
		endcase
	endfunction

	task automatic offer_poll(item_t it);
		while (!calm && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		now_sec <= it.sec;
		now_min <= it.min;
		now_hour <= it.hour;
		now_day <= it.day;
		now_wday <= it.wday;
		now_month <= it.month;
		now_year <= it.year;
		buttons <= it.buttons;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent++;
		calm = (sent >= 400 && sent < 650);
	endtask

	task automatic press(logic [4:0] btn);
		offer_poll(clock_reading(btn));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		item_t it;
		bit drained_mid;
		logic [4:0] alarm_keys [10];
		alarm_keys = '{PRESS_ALARM, PRESS_INC, PRESS_SET,
			PRESS_MODE | PRESS_INC, PRESS_MODE | PRESS_DEC, PRESS_SET, PRESS_ALARM, PRESS_SET,
			PRESS_MODE | PRESS_INC, PRESS_MODE | PRESS_DEC};
		arst_n = 1'b0;
		in_valid = 1'b0;
		now_sec = '0;
		now_min = '0;
		now_hour = '0;
		now_day = '0;
		now_wday = '0;
		now_month = '0;
		now_year = '0;
		buttons = '0;
		calm = 1'b0;
		sent = 0;
		drained_mid = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_poll(reading(0, 0, 0, 1, 0, 1, 0, 5'd0));
		offer_poll(reading(63, 63, 31, 31, 7, 15, 127, 5'd0));
		// Walk the time editor through every field, wrapping each at its limit.
		offer_poll(reading(10, 30, 23, 31, 6, 1, 99, PRESS_MODE));
		offer_poll(reading(10, 30, 23, 31, 6, 1, 99, PRESS_INC));
		offer_poll(reading(11, 30, 0, 31, 6, 1, 99, PRESS_MODE | PRESS_INC));
		offer_poll(reading(12, 30, 0, 1, 0, 1, 99, PRESS_MODE | PRESS_DEC));
		offer_poll(reading(13, 30, 0, 1, 0, 12, 99, PRESS_MODE | PRESS_INC));
		offer_poll(reading(14, 0, 0, 1, 0, 12, 0, PRESS_MODE | PRESS_DEC));
		offer_poll(reading(20, 63, 5, 0, 7, 0, 127, PRESS_DEC));
		offer_poll(reading(45, 59, 5, 1, 0, 1, 0, PRESS_SET | PRESS_INC));
		// Program slot 1, then edit the same slot again to a new time.
		foreach (alarm_keys[i])
			offer_poll(reading(0, 5, 5, 1, 0, 1, 0, alarm_keys[i]));
		offer_poll(reading(0, 5, 5, 1, 0, 1, 0, PRESS_SET));
		offer_poll(reading(30, 59, 1, 1, 0, 1, 0, 5'd0));
		offer_poll(reading(30, 59, 1, 1, 0, 1, 0, PRESS_ALARM));
		offer_poll(reading(31, 59, 1, 1, 0, 1, 0, 5'd0));
		offer_poll(reading(3, 0, 0, 1, 0, 1, 0, PRESS_ALARM));
		offer_poll(reading(0, 59, 1, 1, 0, 1, 0, 5'b11111));

		while (sent < ITEM_TARGET) begin
			if (!drained_mid && sent >= 900) begin
				drain();
				drained_mid = 1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					press(PRESS_ALARM);
					repeat ($urandom_range(0, 5)) press(PRESS_INC);
					press(PRESS_SET);
					repeat ($urandom_range(0, 6)) press(edit_keys());
					press(PRESS_SET);
				end
				3, 4: begin
					repeat ($urandom_range(1, 5)) press(PRESS_MODE);
					repeat ($urandom_range(0, 6)) press(edit_keys());
					press(($urandom_range(0, 1) == 1) ? PRESS_SET : (PRESS_SET | PRESS_INC));
				end
				5, 6, 7, 8: begin
					repeat ($urandom_range(2, 10)) begin
						it = clock_reading(($urandom_range(0, 4) == 0) ? PRESS_ALARM : 5'd0);
						if ($urandom_range(0, 9) == 0) begin
							it.hour = 0;
							it.min = 0;
							it.sec = 6'($urandom_range(0, 3));
						end
						offer_poll(it);
					end
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						it.sec = 6'($urandom_range(0, 63));
						it.min = 6'($urandom_range(0, 63));
						it.hour = 5'($urandom_range(0, 31));
						it.day = 5'($urandom_range(0, 31));
						it.wday = 3'($urandom_range(0, 7));
						it.month = 4'($urandom_range(0, 15));
						it.year = 7'($urandom_range(0, 127));
						it.buttons = 5'($urandom_range(0, 31));
						offer_poll(it);
					end
				end
			endcase
		end

		drain();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// The receiver holds off once for a long stretch so that the block fills and stalls its input.
	initial begin
		int taken;
		int hold_left;
		bit held;
		taken = 0;
		hold_left = 0;
		held = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				taken++;
			if (!held && taken == 500) begin
				held = 1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 17);
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
